// ----- sv/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, command and status codes, and item types for the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Storage geometry. DEPTH is a power of two, so ring arithmetic wraps.
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned STATUS_W   = 2;

  // Command codes on the input item.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_IDX   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE_IDX  = 3'd5;

  // Status codes on the result item.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd3;

  // Decoded operation handed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_READ,
    OP_WRITE,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]             cmd;
    logic signed [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]             index;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] back_value;
    logic [CNT_W-1:0]             count;
    logic [STATUS_W-1:0]          status;
  } out_item_t;

  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]      index;
  } op_t;

endpackage

// ----- sv/dq_front.sv -----
// ----------------------------------------------------------------------------
// Deque front part
// Accepts command items and decodes them into operations for the queue.
// ----------------------------------------------------------------------------
module dq_front import dq_pkg::*; (
  input  logic     start,
  input  in_item_t item_i,
  input  logic     fifo_full_i,
  output logic     busy,
  output logic     push_o,
  output op_t      op_o
);

  // The front part stalls only when the operation queue has no room.
  assign busy   = fifo_full_i;
  assign push_o = start && !fifo_full_i;

  // Decode the command code; unused codes become a no-op.
  always_comb begin
    op_o.value = item_i.value;
    op_o.index = item_i.index;
    unique case (item_i.cmd)
      CMD_PUSH_BACK:  op_o.op = OP_PUSH_BACK;
      CMD_PUSH_FRONT: op_o.op = OP_PUSH_FRONT;
      CMD_POP_BACK:   op_o.op = OP_POP_BACK;
      CMD_POP_FRONT:  op_o.op = OP_POP_FRONT;
      CMD_READ_IDX:   op_o.op = OP_READ;
      CMD_WRITE_IDX:  op_o.op = OP_WRITE;
      default:        op_o.op = OP_NOP;
    endcase
  end

endmodule

// ----- sv/dq_fifo.sv -----
// ----------------------------------------------------------------------------
// Deque operation queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module dq_fifo import dq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  input  logic pop_i,
  output op_t  data_o,
  output logic full_o,
  output logic empty_o
);

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/dq_back.sv -----
// ----------------------------------------------------------------------------
// Deque back part
// Executes one operation on the ring buffer, then reads the front and back
// elements through the single read port and issues the result item.
// ----------------------------------------------------------------------------
module dq_back import dq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fifo_empty_i,
  input  op_t       op_i,
  output logic      pop_o,
  output logic      done_o,
  output out_item_t result_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_FRONT  = 3'd2;
  localparam logic [2:0] ST_BACK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;
  op_t                   cur_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  read_ok_q, read_ok_d;
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] rd_val_q, front_q;
  out_item_t             result_q;

  logic                  full, empty, in_range;
  logic [PTR_W-1:0]      idx_slot, tail_slot, last_slot;
  logic                  we;
  logic [PTR_W-1:0]      waddr, raddr;

  // Ring positions derived from head and count.
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign in_range  = (CNT_W'(cur_q.index) < count_q);
  assign idx_slot  = head_q + PTR_W'(cur_q.index);
  assign tail_slot = head_q + count_q[PTR_W-1:0];
  assign last_slot = head_q + count_q[PTR_W-1:0] - PTR_W'(1);

  assign pop_o = (state_q == ST_IDLE) && !fifo_empty_i;

  // Sequencer and operation execution.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    status_d  = status_q;
    read_ok_d = read_ok_q;
    we        = 1'b0;
    waddr     = idx_slot;
    raddr     = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        status_d  = STATUS_OK;
        read_ok_d = 1'b0;
        raddr     = idx_slot;
        unique case (cur_q.op)
          OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + CNT_W'(1);
              if (cur_q.op == OP_PUSH_BACK) begin
                waddr = tail_slot;
              end else begin
                waddr  = head_q - PTR_W'(1);
                head_d = head_q - PTR_W'(1);
              end
            end
          end
          OP_POP_BACK, OP_POP_FRONT: begin
            if (empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              count_d = count_q - CNT_W'(1);
              if (cur_q.op == OP_POP_FRONT) head_d = head_q + PTR_W'(1);
            end
          end
          OP_READ: begin
            if (in_range) read_ok_d = 1'b1;
            else          status_d  = STATUS_OUT_RANGE;
          end
          OP_WRITE: begin
            if (in_range) we       = 1'b1;
            else          status_d = STATUS_OUT_RANGE;
          end
          default: ;
        endcase
        state_d = ST_FRONT;
      end
      ST_FRONT: begin
        raddr   = head_q;
        state_d = ST_BACK;
      end
      ST_BACK: begin
        raddr   = last_slot;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= (state_q == ST_FINISH);
    end
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= cur_q.value;
    rdata_q <= mem[raddr];
  end

  // Operation latch and result assembly.
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    read_ok_q <= read_ok_d;
    if (pop_o) cur_q <= op_i;
    if (state_q == ST_FRONT) rd_val_q <= read_ok_q ? rdata_q : '0;
    if (state_q == ST_BACK) front_q <= rdata_q;
    if (state_q == ST_FINISH) begin
      result_q.read_value  <= rd_val_q;
      result_q.front_value <= empty ? '0 : front_q;
      result_q.back_value  <= empty ? '0 : rdata_q;
      result_q.count       <= count_q;
      result_q.status      <= status_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  // The element count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("deque count exceeds depth");

  // A result strobe follows the finishing step of the sequencer.
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == ST_FINISH)
    else $error("result strobe without a finished operation");

  // A dropped push is reported only when the ring is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && result_q.status == STATUS_FULL) |-> result_q.count == CNT_W'(DEPTH))
    else $error("full status with free slots");

  // An ignored pop is reported only on an empty ring.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && result_q.status == STATUS_EMPTY) |-> result_q.count == '0)
    else $error("empty status with stored elements");
`endif

endmodule

// ----- sv/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque in a ring buffer with push, pop, and indexed read and write.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      item_i (in_item_t)
// result    out        done_o strobe, one cycle  result_o (out_item_t)
//
// Each item passes through the back part in order: execute with an indexed
// read, then two reads of the front and back slots through the single
// read port of the element store, then result assembly and the strobe.
// A two-entry operation queue lets up to two items wait behind it; busy
// is high while that queue is full. Reset clears head and count at once.
// The receiver cannot stall; done_o marks every result for exactly one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_item_t  item_i,
  output logic      busy,
  output logic      done_o,
  output out_item_t result_o
);

  logic fifo_full, fifo_empty, fifo_push, fifo_pop;
  op_t  front_op, back_op;

  // Decode incoming items.
  dq_front u_front (
    .start       (start),
    .item_i      (item_i),
    .fifo_full_i (fifo_full),
    .busy        (busy),
    .push_o      (fifo_push),
    .op_o        (front_op)
  );

  // Queue between decode and execution.
  dq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_op),
    .pop_i   (fifo_pop),
    .data_o  (back_op),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // Execute operations on the ring buffer.
  dq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .op_i         (back_op),
    .pop_o        (fifo_pop),
    .done_o       (done_o),
    .result_o     (result_o)
  );

endmodule

// ----- bench/dq_checker.sv -----
// ----------------------------------------------------------------------------
// Deque result checker
// Watches the command and result channels of the double-ended queue. It
// keeps its own copy of the ring, head and fill level, works out the view
// that each accepted command should produce, and compares every result
// strobe field by field with the oldest view still awaited.
// ----------------------------------------------------------------------------
module dq_checker import dq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  item_i,
  input  logic      done_o,
  input  out_item_t result_o,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the deque state.
  logic [DATA_WIDTH-1:0] shadow_ring [DEPTH];
  logic [PTR_W-1:0]      shadow_head;
  logic [CNT_W-1:0]      shadow_fill;

  // Views predicted for commands that have been accepted but not answered.
  out_item_t awaited_views [$];
  int        mismatch_total;

  // Applies one command to the shadow state and returns the view it yields.
  task automatic deque_apply(input in_item_t c, output out_item_t v);
    logic [PTR_W-1:0] slot;
    v = '0;
    v.status = STATUS_OK;
    case (c.cmd)
      CMD_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          v.status = STATUS_FULL;
        end else begin
          slot = shadow_head + shadow_fill[PTR_W-1:0];
          shadow_ring[slot] = c.value;
          shadow_fill++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (shadow_fill == DEPTH) begin
          v.status = STATUS_FULL;
        end else begin
          shadow_head = shadow_head - 1'b1;
          shadow_ring[shadow_head] = c.value;
          shadow_fill++;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_fill == 0) v.status = STATUS_EMPTY;
        else shadow_fill--;
      end
      CMD_POP_FRONT: begin
        if (shadow_fill == 0) begin
          v.status = STATUS_EMPTY;
        end else begin
          shadow_head = shadow_head + 1'b1;
          shadow_fill--;
        end
      end
      CMD_READ_IDX: begin
        slot = shadow_head + c.index;
        if (c.index >= shadow_fill) v.status = STATUS_OUT_RANGE;
        else v.read_value = shadow_ring[slot];
      end
      CMD_WRITE_IDX: begin
        slot = shadow_head + c.index;
        if (c.index >= shadow_fill) v.status = STATUS_OUT_RANGE;
        else shadow_ring[slot] = c.value;
      end
      default: begin
        // Codes six and seven leave the deque alone.
      end
    endcase
    // Front and back read zero while the deque is empty.
    if (shadow_fill != 0) begin
      slot = shadow_head + shadow_fill[PTR_W-1:0] - 1'b1;
      v.front_value = shadow_ring[shadow_head];
      v.back_value  = shadow_ring[slot];
    end
    v.count = shadow_fill;
  endtask

  // Reports one field that differs and returns how many failures it adds.
  function automatic int field_differs(string field, logic signed [63:0] want,
                                       logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Results are checked before the command of the same edge is modeled;
  // a result never belongs to a command accepted at that same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t view;
    if (!rst_ni) begin
      shadow_head = '0;
      shadow_fill = '0;
      awaited_views.delete();
      mismatch_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_o) begin
        if (awaited_views.size() == 0) begin
          $error("result strobe with no command outstanding");
          mismatch_total++;
        end else begin
          want = awaited_views.pop_front();
          mismatch_total += field_differs("read_value", want.read_value,
                                          result_o.read_value);
          mismatch_total += field_differs("front_value", want.front_value,
                                          result_o.front_value);
          mismatch_total += field_differs("back_value", want.back_value,
                                          result_o.back_value);
          mismatch_total += field_differs("count", want.count, result_o.count);
          mismatch_total += field_differs("status", want.status, result_o.status);
        end
      end
      if (start && !busy) begin
        deque_apply(item_i, view);
        awaited_views.push_back(view);
      end
      fail_count_o <= mismatch_total;
      pending_o    <= awaited_views.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Deque testbench top
// Drives commands into the double-ended queue: a directed pass over the
// empty, full and out-of-range cases, then random runs biased toward
// filling, draining, indexed access or a free mix, under three sender
// idle rates. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the block treats as no operation.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // Margin for the item in the back part with two more queued ahead.
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_ITEMS  = 510;

  typedef enum int {FILL_RUN, DRAIN_RUN, ACCESS_RUN, MIXED_RUN} run_kind_e;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_item_t  item_i;
  logic      busy;
  logic      done_o;
  out_item_t result_o;
  int        fail_count;
  int        pending;
  int        cycle_count;

  double_ended_queue dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  dq_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Ends a run that has stopped making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Values at the edges of the signed range.
  function automatic logic [DATA_WIDTH-1:0] corner_value(int k);
    case (k)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic in_item_t make_cmd(logic [CMD_W-1:0] cmd,
                                        logic [DATA_WIDTH-1:0] value,
                                        logic [IDX_W-1:0] index);
    in_item_t c;
    c.cmd   = cmd;
    c.value = value;
    c.index = index;
    return c;
  endfunction

  // Picks a command whose mix depends on the kind of run in progress.
  function automatic in_item_t random_command(run_kind_e kind);
    in_item_t c;
    int       roll;
    roll    = $urandom_range(99);
    c.value = ($urandom_range(7) == 0) ? corner_value($urandom_range(3)) : $urandom;
    c.index = IDX_W'($urandom_range(15));
    c.cmd   = CMD_W'($urandom_range(7));
    case (kind)
      FILL_RUN:
        if (roll < 80) c.cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      DRAIN_RUN:
        if (roll < 80) c.cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      ACCESS_RUN:
        if (roll < 70) c.cmd = $urandom_range(1) ? CMD_WRITE_IDX : CMD_READ_IDX;
      default: begin
      end
    endcase
    return c;
  endfunction

  // Offers one item, idling first at the given rate, and returns at the
  // edge that accepts it.
  task automatic drive_command(input in_item_t c, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Holds the command channel quiet until every result has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct);
    int        sent;
    int        run_len;
    run_kind_e kind;
    sent = 0;
    while (sent < n_items) begin
      kind    = run_kind_e'($urandom_range(3));
      run_len = $urandom_range(40, 6);
      // The last run of a phase stops at the phase's item count.
      if (run_len > n_items - sent) run_len = n_items - sent;
      repeat (run_len) begin
        drive_command(random_command(kind), idle_pct);
        sent++;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty deque: pops are ignored, reads are out of range, spare codes idle.
    drive_command(make_cmd(CMD_POP_BACK, 32'h0, 4'd0), 0);
    drive_command(make_cmd(CMD_POP_FRONT, 32'h0, 4'd0), 0);
    drive_command(make_cmd(CMD_READ_IDX, 32'h0, 4'd0), 0);
    drive_command(make_cmd(CMD_SPARE_6, 32'hffff_ffff, 4'd15), 0);
    drive_command(make_cmd(CMD_SPARE_7, 32'h0, 4'd0), 0);

    // Fill from both ends, starting with the corner values.
    for (int i = 0; i < DEPTH; i++) begin
      drive_command(make_cmd(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                             (i < 4) ? corner_value(i) : $urandom, 4'd0), 0);
    end

    // Full deque: both pushes are dropped; the last index is reachable.
    drive_command(make_cmd(CMD_PUSH_BACK, 32'h1234_5678, 4'd0), 0);
    drive_command(make_cmd(CMD_PUSH_FRONT, 32'h8765_4321, 4'd0), 0);
    drive_command(make_cmd(CMD_READ_IDX, 32'h0, 4'd15), 0);
    drive_command(make_cmd(CMD_WRITE_IDX, $urandom, 4'd15), 0);
    drive_command(make_cmd(CMD_POP_FRONT, 32'h0, 4'd0), 0);
    drive_command(make_cmd(CMD_POP_BACK, 32'h0, 4'd0), 0);

    // With fourteen left, index fifteen is out of range for a write.
    drive_command(make_cmd(CMD_WRITE_IDX, $urandom, 4'd15), 0);
    hold_until_drained();

    run_random_phase(PHASE_ITEMS, 34);
    hold_until_drained();
    run_random_phase(PHASE_ITEMS, 71);
    hold_until_drained();
    run_random_phase(PHASE_ITEMS, 0);
    hold_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dq_pkg.sv
sv/dq_front.sv
sv/dq_fifo.sv
sv/dq_back.sv
sv/double_ended_queue.sv
bench/dq_checker.sv
bench/tb_top.sv
